FILE: src/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free-list block allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int FREE_SLOTS_DEF = 16;
    localparam int HEADER_BYTES   = 16;
    localparam int HEAP_BYTES     = 65536;

    localparam int SIZE_W   = 16;
    localparam int TOTAL_W  = 32;
    localparam int TOP_W    = 17;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 112;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_policy_t;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_REUSED   = 3'd1,
        ST_RELEASED = 3'd2,
        ST_OOM      = 3'd3,
        ST_FLAG     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC
    } state_t;

    localparam logic [ADDR_W-1:0] REG_FIT_POLICY = 3'd0;
    localparam logic [ADDR_W-1:0] REG_HEAP_LIMIT = 3'd4;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] surplus;
    } cand_t;

endpackage

FILE: src/fla_cell.sv
// ----------------------------------------------------------------------------
// fla_cell
// One table entry: holds an address and a size, takes its neighbor's entry
// on a removal, and scores itself against the current request.
// ----------------------------------------------------------------------------
module fla_cell (
    input  logic                          clk,
    input  fla_pkg::cell_ctrl_t           ctrl,
    input  fla_pkg::fit_policy_t          policy,
    input  logic                          active,
    input  logic [fla_pkg::SIZE_W-1:0]    req,
    input  logic [fla_pkg::SIZE_W-1:0]    next_addr,
    input  logic [fla_pkg::SIZE_W-1:0]    next_size,
    input  logic [fla_pkg::SIZE_W-1:0]    load_addr,
    input  logic [fla_pkg::SIZE_W-1:0]    load_size,
    output logic [fla_pkg::SIZE_W-1:0]    addr,
    output logic [fla_pkg::SIZE_W-1:0]    size,
    output fla_pkg::cand_t                cand
);
    import fla_pkg::*;

    logic [SIZE_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    cand_t             cand_reg;
    cand_t             cand_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            addr_reg <= load_addr;
            size_reg <= load_size;
        end
        else if (ctrl.shift)
        begin
            addr_reg <= next_addr;
            size_reg <= next_size;
        end
    end

    always_comb
    begin
        cand_next.surplus = size_reg - req;
        case (policy) inside
            FIT_BEST, FIT_WORST: cand_next.found = active && (size_reg > req);
            default:             cand_next.found = active && (size_reg >= req);
        endcase
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign addr = addr_reg;
    assign size = size_reg;
    assign cand = cand_reg;

endmodule

FILE: src/fla_pick.sv
// ----------------------------------------------------------------------------
// fla_pick
// Registered selection tree over the cell scores; the earlier entry wins ties.
// ----------------------------------------------------------------------------
module fla_pick #(
    parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF
) (
    input  logic                          clk,
    input  fla_pkg::fit_policy_t          policy,
    input  fla_pkg::cand_t                cand [FREE_SLOTS],
    output logic                          found,
    output logic [$clog2(FREE_SLOTS)-1:0] idx
);
    import fla_pkg::*;

    localparam int IW     = $clog2(FREE_SLOTS);
    localparam int LEVELS = $clog2(FREE_SLOTS);
    localparam int PAD    = 1 << LEVELS;

    typedef struct packed {
        logic              found;
        logic [IW-1:0]     idx;
        logic [SIZE_W-1:0] surplus;
    } node_t;

    function automatic node_t pick2(node_t a, node_t b, fit_policy_t pol);
        node_t r;
        r = a;
        if (!a.found)
        begin
            r = b;
        end
        else if (b.found)
        begin
            case (pol)
                FIT_BEST:  if (b.surplus < a.surplus) r = b;
                FIT_WORST: if (b.surplus > a.surplus) r = b;
                default:   r = a;
            endcase
        end
        return r;
    endfunction

    node_t tree [0:LEVELS][0:PAD-1];

    for (genvar n = 0; n < PAD; n++)
    begin : g_leaf
        if (n < FREE_SLOTS)
        begin : g_used
            assign tree[0][n] = '{found: cand[n].found, idx: IW'(n),
                                  surplus: cand[n].surplus};
        end
        else
        begin : g_pad
            assign tree[0][n] = '0;
        end
    end

    for (genvar lv = 1; lv <= LEVELS; lv++)
    begin : g_level
        for (genvar n = 0; n < (PAD >> lv); n++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                tree[lv][n] <= pick2(tree[lv-1][2*n], tree[lv-1][2*n+1], policy);
            end
        end
    end

    assign found = tree[LEVELS][0].found;
    assign idx   = tree[LEVELS][0].idx;

endmodule

FILE: src/free_list_block_allocator.sv
// ----------------------------------------------------------------------------
// free_list_block_allocator
// Heap allocator with an ordered free table held in a chain of cells.
// ----------------------------------------------------------------------------
// Allocate: the item is latched, scored in the cell registers, passed through
//   the registered levels of the pick tree and applied to the output register.
//   Release, clear: go from accept straight to the apply step.
// One item in work at a time; a new item is taken while a result waits, and an
//   item is applied only when the output register is empty or being read.
// Reset empties the table, zeroes the heap top and counters, restores config.
// ----------------------------------------------------------------------------
module free_list_block_allocator #(
    parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fla_pkg::ADDR_W-1:0]     paddr,
    input  logic [fla_pkg::DATA_W-1:0]     pwdata,
    output logic [fla_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fla_pkg::S_DATA_W-1:0]   s_tdata,  // request_size, release_address, release_size
    input  logic [1:0]                     s_tuser,  // command
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fla_pkg::M_DATA_W-1:0]   m_tdata,  // data_address, new_total, release_total, reuse_total
    output logic [2:0]                     m_tuser   // status
);
    import fla_pkg::*;

    localparam int IW     = $clog2(FREE_SLOTS);
    localparam int NW     = $clog2(FREE_SLOTS + 1);
    localparam int LEVELS = $clog2(FREE_SLOTS);
    localparam int WW     = $clog2(LEVELS + 2);
    localparam logic [SIZE_W-1:0] HEAP_MAX = SIZE_W'(HEAP_BYTES - 1);

    // configuration
    fit_policy_t        fit_policy_reg;
    logic [SIZE_W-1:0]  heap_limit_reg;
    logic               cfg_wr;

    // control
    state_t             state_reg;
    state_t             state_next;
    logic [WW-1:0]      wait_reg;
    logic               accept;
    logic               exec_go;

    // latched item
    command_t           cmd_reg;
    logic [SIZE_W-1:0]  req_reg;
    logic [SIZE_W-1:0]  raddr_reg;
    logic [SIZE_W-1:0]  rsize_reg;

    // heap and table state
    logic [NW-1:0]      count_reg;
    logic [TOP_W-1:0]   heap_top_reg;
    logic [TOTAL_W-1:0] new_total_reg;
    logic [TOTAL_W-1:0] release_total_reg;
    logic [TOTAL_W-1:0] reuse_total_reg;

    // output register
    logic               m_tvalid_reg;
    logic [SIZE_W-1:0]  out_addr_reg;
    status_t            out_status_reg;

    // cells and pick tree
    logic [SIZE_W-1:0]  cell_addr [FREE_SLOTS];
    logic [SIZE_W-1:0]  cell_size [FREE_SLOTS];
    cand_t              cand      [FREE_SLOTS];
    cell_ctrl_t         ctrl      [FREE_SLOTS];
    logic               pick_found;
    logic [IW-1:0]      pick_idx;

    // result of the applied item
    logic [TOP_W:0]     fresh_start;
    logic [TOP_W:0]     fresh_top;
    logic [SIZE_W-1:0]  bound;
    logic               oom;
    logic               table_full;
    logic [SIZE_W-1:0]  res_addr;
    status_t            res_status;

    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= FIT_FIRST;
            heap_limit_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                REG_FIT_POLICY: fit_policy_reg <= fit_policy_t'(pwdata[1:0]);
                REG_HEAP_LIMIT: heap_limit_reg <= pwdata[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_FIT_POLICY: prdata = {30'd0, fit_policy_reg};
            REG_HEAP_LIMIT: prdata = {16'd0, heap_limit_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                wait_reg <= WW'(LEVELS);
            end
            else if (state_reg == S_SEARCH)
            begin
                wait_reg <= wait_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        exec_go    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = (command_t'(s_tuser) == CMD_ALLOC) ? S_SEARCH : S_EXEC;
                end
            end
            S_SEARCH:
            begin
                if (wait_reg == '0)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                exec_go = !m_tvalid_reg || m_tready;
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command_t'(s_tuser);
            req_reg   <= s_tdata[15:0];
            raddr_reg <= s_tdata[31:16];
            rsize_reg <= s_tdata[47:32];
        end
    end

    // ------------------------------------------------------------------------
    for (genvar i = 0; i < FREE_SLOTS; i++)
    begin : g_cell
        logic [SIZE_W-1:0] nb_addr;
        logic [SIZE_W-1:0] nb_size;

        if (i < FREE_SLOTS - 1)
        begin : g_mid
            assign nb_addr = cell_addr[i+1];
            assign nb_size = cell_size[i+1];
        end
        else
        begin : g_end
            assign nb_addr = cell_addr[i];
            assign nb_size = cell_size[i];
        end

        assign ctrl[i].shift = exec_go && (cmd_reg == CMD_ALLOC) && pick_found
                               && (IW'(i) >= pick_idx);
        assign ctrl[i].load  = exec_go && (cmd_reg == CMD_RELEASE) && (count_reg == NW'(i));

        fla_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .policy    (fit_policy_reg),
            .active    (NW'(i) < count_reg),
            .req       (req_reg),
            .next_addr (nb_addr),
            .next_size (nb_size),
            .load_addr (raddr_reg),
            .load_size (rsize_reg),
            .addr      (cell_addr[i]),
            .size      (cell_size[i]),
            .cand      (cand[i])
        );
    end

    fla_pick #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_pick (
        .clk    (clk),
        .policy (fit_policy_reg),
        .cand   (cand),
        .found  (pick_found),
        .idx    (pick_idx)
    );

    // ------------------------------------------------------------------------
    always_comb
    begin
        fresh_start = {1'b0, heap_top_reg} + (TOP_W + 1)'(HEADER_BYTES);
        fresh_top   = fresh_start + (TOP_W + 1)'(req_reg);
        bound       = (heap_limit_reg < HEAP_MAX) ? heap_limit_reg : HEAP_MAX;
        oom         = fresh_top > {2'b00, bound};
        table_full  = count_reg >= NW'(FREE_SLOTS);
        res_addr    = '0;
        res_status  = ST_FLAG;
        unique case (cmd_reg)
            CMD_ALLOC:
            begin
                if (pick_found)
                begin
                    res_addr   = cell_addr[pick_idx];
                    res_status = ST_REUSED;
                end
                else if (oom)
                begin
                    res_status = ST_OOM;
                end
                else
                begin
                    res_addr   = fresh_start[SIZE_W-1:0];
                    res_status = ST_NEW;
                end
            end
            CMD_RELEASE:
            begin
                res_status = table_full ? ST_FLAG : ST_RELEASED;
            end
            default:
            begin
                res_status = ST_FLAG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            heap_top_reg      <= '0;
            new_total_reg     <= '0;
            release_total_reg <= '0;
            reuse_total_reg   <= '0;
        end
        else if (exec_go)
        begin
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (pick_found)
                    begin
                        count_reg       <= count_reg - 1'b1;
                        reuse_total_reg <= reuse_total_reg + 1'b1;
                    end
                    else if (!oom)
                    begin
                        heap_top_reg  <= fresh_top[TOP_W-1:0];
                        new_total_reg <= new_total_reg + 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    if (!table_full)
                    begin
                        count_reg         <= count_reg + 1'b1;
                        release_total_reg <= release_total_reg + 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    count_reg    <= '0;
                    heap_top_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status;
        end
    end

    // counters only move when the output register is reloaded
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {reuse_total_reg, release_total_reg, new_total_reg, out_addr_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(FREE_SLOTS))
        else $error("free table count above capacity");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_top_reg <= TOP_W'(HEAP_BYTES - 1))
        else $error("heap top beyond heap size");

    a_hit_removes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && cmd_reg == CMD_ALLOC && pick_found)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("reuse did not remove exactly one entry");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_EXEC)
        else $error("result shown without an applied item");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg == CMD_ALLOC && pick_found)
        |-> NW'(pick_idx) < count_reg)
        else $error("pick outside the filled table");

endmodule
